[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a second one in the same cycle.
`define ASSERT_IMPLIES(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

[hdl/erq_pkg.sv]
// ----------------------------------------------------------------------------
// erq_pkg
// Types and command codes of the event ring queue.
// ----------------------------------------------------------------------------
`default_nettype none

package erq_pkg;

  // Command codes
  typedef enum logic [1:0] {
    CMD_POST  = 2'd0,
    CMD_GET   = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_e;

  // One command transaction
  typedef struct packed {
    cmd_e        command;
    logic [5:0]  event_type;
    logic [1:0]  event_priority;
    logic [31:0] event_time;
    logic [31:0] event_payload;
    logic [31:0] now_ms;
  } erq_in_t;

  // One result transaction
  typedef struct packed {
    logic        ok;
    logic        overflow;
    logic [5:0]  out_type;
    logic [1:0]  out_priority;
    logic [31:0] out_time;
    logic [31:0] out_payload;
    logic        handled;
    logic [3:0]  fill_count;
    logic [31:0] posted_total;
    logic [31:0] lost_total;
    logic [31:0] consumed_total;
  } erq_out_t;

  // Stored event header
  typedef struct packed {
    logic [5:0]  etype;
    logic [1:0]  prio;
    logic [31:0] etime;
  } erq_hdr_t;

  // Per-cell control: shift toward the head, load the new event
  typedef struct packed {
    logic shift;
    logic load;
  } erq_cell_ctl_t;

endpackage

`default_nettype wire

[hdl/erq_cell.sv]
// ----------------------------------------------------------------------------
// erq_cell
// One queue slot: loads the posted event or takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module erq_cell #(
  parameter int PAYLOAD_W = 32
) (
  input  wire logic                    clk,
  input  wire erq_pkg::erq_cell_ctl_t  ctl,
  input  wire erq_pkg::erq_hdr_t       nbr_hdr,
  input  wire logic [PAYLOAD_W-1:0]    nbr_pay,
  input  wire erq_pkg::erq_hdr_t       wr_hdr,
  input  wire logic [PAYLOAD_W-1:0]    wr_pay,
  output erq_pkg::erq_hdr_t            hdr,
  output logic [PAYLOAD_W-1:0]         pay
);
  import erq_pkg::*;

  // Load wins over shift so the tail cell takes the new event on overwrite
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      hdr <= wr_hdr;
      pay <= wr_pay;
    end else if (ctl.shift) begin
      hdr <= nbr_hdr;
      pay <= nbr_pay;
    end
  end

endmodule

`default_nettype wire

[hdl/erq_ctrl.sv]
// ----------------------------------------------------------------------------
// erq_ctrl
// Command decode, occupancy, statistics counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module erq_ctrl #(
  parameter int DEPTH     = 8,
  parameter int PAYLOAD_W = 32,
  parameter int IDX_W     = $clog2(DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    take,
  input  wire erq_pkg::erq_in_t        request,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_bit,
  input  wire erq_pkg::erq_hdr_t       head_hdr,
  input  wire logic [PAYLOAD_W-1:0]    head_pay,
  output erq_pkg::erq_cell_ctl_t       cell_cmd,
  output logic [IDX_W-1:0]             wr_idx,
  output erq_pkg::erq_hdr_t            wr_hdr,
  output logic [PAYLOAD_W-1:0]         wr_pay,
  output logic                         done,
  output erq_pkg::erq_out_t            result
);
  import erq_pkg::*;

  localparam int OCC_W = $clog2(DEPTH + 1);

  logic             overwrite;
  logic [OCC_W-1:0] occ, occ_next;
  logic [31:0]      posted, posted_next;
  logic [31:0]      lost, lost_next;
  logic [31:0]      consumed, consumed_next;
  erq_cell_ctl_t    cc;
  erq_out_t         res_next;
  logic             full;

  // Build the event to store; a zero timestamp takes the current tick
  always_comb begin
    wr_hdr.etype = request.event_type;
    wr_hdr.prio  = request.event_priority;
    wr_hdr.etime = (request.event_time == 32'd0) ? request.now_ms : request.event_time;
    wr_pay       = PAYLOAD_W'(request.event_payload);
  end

  assign full = (occ == OCC_W'(DEPTH));

  // Decode the command into cell controls, next counters and the result
  always_comb begin
    occ_next      = occ;
    posted_next   = posted;
    lost_next     = lost;
    consumed_next = consumed;
    cc            = '0;
    wr_idx        = occ[IDX_W-1:0];
    res_next      = '0;
    case (request.command)
      CMD_POST: begin
        posted_next = posted + 32'd1;
        if (full) begin
          lost_next = lost + 32'd1;
          if (overwrite) begin
            // drop the oldest, append at the far end
            cc.shift     = 1'b1;
            cc.load      = 1'b1;
            wr_idx       = IDX_W'(DEPTH - 1);
            res_next.ok  = 1'b1;
          end else begin
            res_next.overflow = 1'b1;
          end
        end else begin
          cc.load     = 1'b1;
          occ_next    = occ + OCC_W'(1);
          res_next.ok = 1'b1;
        end
      end
      CMD_GET, CMD_PEEK: begin
        if (occ != '0) begin
          res_next.ok           = 1'b1;
          res_next.out_type     = head_hdr.etype;
          res_next.out_priority = head_hdr.prio;
          res_next.out_time     = head_hdr.etime;
          res_next.out_payload  = 32'(head_pay);
          if (request.command == CMD_GET) begin
            cc.shift          = 1'b1;
            occ_next          = occ - OCC_W'(1);
            consumed_next     = consumed + 32'd1;
            res_next.handled  = 1'b1;
          end
        end
      end
      CMD_FLUSH: begin
        occ_next    = '0;
        res_next.ok = 1'b1;
      end
      default: begin
        res_next = '0;
      end
    endcase
    res_next.fill_count     = 4'(occ_next);
    res_next.posted_total   = posted_next;
    res_next.lost_total     = lost_next;
    res_next.consumed_total = consumed_next;
  end

  // Act on the cells only for an accepted transaction
  assign cell_cmd = take ? cc : '0;

  // Hold the mode bit and the queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      overwrite <= 1'b0;
      occ       <= '0;
      posted    <= '0;
      lost      <= '0;
      consumed  <= '0;
      done      <= 1'b0;
    end else begin
      if (cfg_we) begin
        overwrite <= cfg_bit;
      end
      if (take) begin
        occ      <= occ_next;
        posted   <= posted_next;
        lost     <= lost_next;
        consumed <= consumed_next;
      end
      done <= take;
    end
  end

  // Register the result of each accepted command
  always_ff @(posedge clk) begin
    if (take) begin
      result <= res_next;
    end
  end

endmodule

`default_nettype wire

[hdl/event_ring_queue_overwrite_core.sv]
// ----------------------------------------------------------------------------
// event_ring_queue_overwrite_core
// Event queue with overwrite of the oldest entry, built as a row of cells.
// ----------------------------------------------------------------------------
// The result appears on result with done in the cycle after start is taken.
// Throughput: one command per cycle while rst is low; the cell row and counters
//   update together, the head entry always sits in cell 0.
// Reset: synchronous; clears fill count, statistics and overwrite mode, busy
//   is high while rst is high. Entry storage is not cleared.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

`include "assert_macros.svh"

module event_ring_queue_overwrite_core #(
  parameter int QUEUE_DEPTH  = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire erq_pkg::erq_in_t   request,
  output logic                    done,
  output erq_pkg::erq_out_t       result,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_data
);
  import erq_pkg::*;

  localparam int STORE_W = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
  localparam int IDX_W   = $clog2(QUEUE_DEPTH);

  logic                accept;
  erq_cell_ctl_t       cmd;
  logic [IDX_W-1:0]    wr_idx;
  erq_hdr_t            wr_hdr;
  logic [STORE_W-1:0]  wr_pay;
  erq_hdr_t            hdr [QUEUE_DEPTH];
  logic [STORE_W-1:0]  pay [QUEUE_DEPTH];
  erq_cell_ctl_t       cell_ctl [QUEUE_DEPTH];

  // Handshakes
  assign busy      = rst;
  assign cfg_ready = ~rst;
  assign accept    = start & ~busy;

  // Control and counters
  erq_ctrl #(
    .DEPTH     (QUEUE_DEPTH),
    .PAYLOAD_W (STORE_W),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .take     (accept),
    .request  (request),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_bit  (cfg_data),
    .head_hdr (hdr[0]),
    .head_pay (pay[0]),
    .cell_cmd (cmd),
    .wr_idx   (wr_idx),
    .wr_hdr   (wr_hdr),
    .wr_pay   (wr_pay),
    .done     (done),
    .result   (result)
  );

  // Row of cells, cell 0 holds the oldest event
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign cell_ctl[i].shift = cmd.shift;
    assign cell_ctl[i].load  = cmd.load && (wr_idx == IDX_W'(i));

    if (i == QUEUE_DEPTH - 1) begin : g_last
      erq_cell #(.PAYLOAD_W(STORE_W)) u_cell (
        .clk     (clk),
        .ctl     (cell_ctl[i]),
        .nbr_hdr (wr_hdr),
        .nbr_pay (wr_pay),
        .wr_hdr  (wr_hdr),
        .wr_pay  (wr_pay),
        .hdr     (hdr[i]),
        .pay     (pay[i])
      );
    end else begin : g_mid
      erq_cell #(.PAYLOAD_W(STORE_W)) u_cell (
        .clk     (clk),
        .ctl     (cell_ctl[i]),
        .nbr_hdr (hdr[i+1]),
        .nbr_pay (pay[i+1]),
        .wr_hdr  (wr_hdr),
        .wr_pay  (wr_pay),
        .hdr     (hdr[i]),
        .pay     (pay[i])
      );
    end
  end

  // Assertions
  `ASSERT_ALWAYS(a_done_follows_accept, done == $past(accept), "done without accepted command")
  `ASSERT_IMPLIES(a_handled_is_ok, done && result.handled, result.ok, "handled without ok")
  `ASSERT_IMPLIES(a_overflow_fails, done && result.overflow, !result.ok, "overflow with ok")

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the event ring queue core. A scoreboard class keeps
// its own copy of the queue, pointers and statistics, predicts one result per
// accepted command and compares every strobed result field by field. Stimulus
// is a directed walk through empty reads, full rejects, overwrite and flush,
// then random command mixes under both overwrite modes with random idle gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import erq_pkg::*;

  localparam int DEPTH        = 8;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 100;

  // Reference copy of the queue and its statistics
  class erq_scoreboard;
    erq_out_t    expected_q[$];
    erq_hdr_t    slot_hdr[DEPTH];
    logic [31:0] slot_pay[DEPTH];
    int          head_idx;
    int          tail_idx;
    int          occupancy;
    logic [31:0] posted_cnt;
    logic [31:0] lost_cnt;
    logic [31:0] consumed_cnt;
    bit          overwrite_on;
    int          errors;
    int          checked;
    int          full_rejects;
    int          full_overwrites;
    int          empty_reads;

    function new();
      head_idx        = 0;
      tail_idx        = 0;
      occupancy       = 0;
      posted_cnt      = '0;
      lost_cnt        = '0;
      consumed_cnt    = '0;
      overwrite_on    = 1'b0;
      errors          = 0;
      checked         = 0;
      full_rejects    = 0;
      full_overwrites = 0;
      empty_reads     = 0;
    endfunction

    function int next_idx(int p);
      return (p + 1 >= DEPTH) ? 0 : p + 1;
    endfunction

    function void set_overwrite(bit v);
      overwrite_on = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Apply one accepted command and queue the result it must produce
    function void note_command(erq_in_t c);
      erq_out_t    r;
      logic [31:0] stamp;
      bit          store;
      r = '0;
      case (c.command)
        CMD_POST: begin
          store = 1'b1;
          posted_cnt = posted_cnt + 1;
          if (occupancy >= DEPTH) begin
            lost_cnt = lost_cnt + 1;
            if (overwrite_on) begin
              head_idx = next_idx(head_idx);
              occupancy--;
              full_overwrites++;
            end else begin
              store = 1'b0;
              r.overflow = 1'b1;
              full_rejects++;
            end
          end
          if (store) begin
            stamp = (c.event_time == 32'd0) ? c.now_ms : c.event_time;
            slot_hdr[tail_idx].etype = c.event_type;
            slot_hdr[tail_idx].prio  = c.event_priority;
            slot_hdr[tail_idx].etime = stamp;
            slot_pay[tail_idx]       = c.event_payload;
            tail_idx = next_idx(tail_idx);
            occupancy++;
            r.ok = 1'b1;
          end
        end
        CMD_GET, CMD_PEEK: begin
          if (occupancy != 0) begin
            r.ok           = 1'b1;
            r.out_type     = slot_hdr[head_idx].etype;
            r.out_priority = slot_hdr[head_idx].prio;
            r.out_time     = slot_hdr[head_idx].etime;
            r.out_payload  = slot_pay[head_idx];
            if (c.command == CMD_GET) begin
              head_idx = next_idx(head_idx);
              occupancy--;
              consumed_cnt = consumed_cnt + 1;
              r.handled = 1'b1;
            end
          end else begin
            empty_reads++;
          end
        end
        default: begin
          head_idx  = 0;
          tail_idx  = 0;
          occupancy = 0;
          r.ok      = 1'b1;
        end
      endcase
      r.fill_count     = occupancy[3:0];
      r.posted_total   = posted_cnt;
      r.lost_total     = lost_cnt;
      r.consumed_total = consumed_cnt;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Match one strobed result against the oldest prediction
    function void check_result(erq_out_t a);
      erq_out_t e;
      if (expected_q.size() == 0) begin
        $error("result strobed with no command outstanding");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      compare_field("ok",             32'(e.ok),             32'(a.ok));
      compare_field("overflow",       32'(e.overflow),       32'(a.overflow));
      compare_field("out_type",       32'(e.out_type),       32'(a.out_type));
      compare_field("out_priority",   32'(e.out_priority),   32'(a.out_priority));
      compare_field("out_time",       e.out_time,            a.out_time);
      compare_field("out_payload",    e.out_payload,         a.out_payload);
      compare_field("handled",        32'(e.handled),        32'(a.handled));
      compare_field("fill_count",     32'(e.fill_count),     32'(a.fill_count));
      compare_field("posted_total",   e.posted_total,        a.posted_total);
      compare_field("lost_total",     e.lost_total,          a.lost_total);
      compare_field("consumed_total", e.consumed_total,      a.consumed_total);
    endfunction
  endclass

  logic     clk;
  logic     rst       = 1'b1;
  logic     start     = 1'b0;
  erq_in_t  request   = '0;
  logic     cfg_valid = 1'b0;
  logic     cfg_data  = 1'b0;
  logic     busy;
  logic     done;
  erq_out_t result;
  logic     cfg_ready;

  erq_scoreboard sb = new();
  int            issued = 0;

  event_ring_queue_overwrite_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Clock generation
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watch both channels at each edge: note accepted commands and mode writes
  // first, then check any strobed result
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) sb.set_overwrite(cfg_data);
      if (start === 1'b1 && busy === 1'b0) sb.note_command(request);
      if (done === 1'b1) sb.check_result(result);
    end
  end

  // Hold a command on the port until the block takes it
  task automatic issue_command(erq_in_t c);
    request <= c;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    issued++;
  endtask

  // Drop start and leave the command port idle
  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop issuing and wait until every result has come back
  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // One transaction on the mode register
  task automatic write_overwrite(bit v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  function automatic erq_in_t post_event(logic [5:0] t, logic [1:0] p, logic [31:0] ts,
                                         logic [31:0] pay, logic [31:0] now);
    erq_in_t c;
    c.command        = CMD_POST;
    c.event_type     = t;
    c.event_priority = p;
    c.event_time     = ts;
    c.event_payload  = pay;
    c.now_ms         = now;
    return c;
  endfunction

  function automatic erq_in_t plain_command(cmd_e op);
    erq_in_t c;
    c = post_event(6'($urandom), 2'($urandom), $urandom, $urandom, $urandom);
    c.command = op;
    return c;
  endfunction

  // Random command; post_pct sets how hard the queue is pushed toward full
  function automatic erq_in_t random_command(int post_pct);
    erq_in_t c;
    int      r;
    logic [31:0] ts;
    logic [31:0] now;
    r   = $urandom_range(0, 99);
    ts  = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom;
    case ($urandom_range(0, 9))
      0:       now = 32'd0;
      1:       now = 32'hFFFF_FFFF;
      default: now = $urandom;
    endcase
    c = post_event(6'($urandom), 2'($urandom), ts, $urandom, now);
    if (r < post_pct)             c.command = CMD_POST;
    else if (r < 96)              c.command = ($urandom_range(0, 2) != 0) ? CMD_GET : CMD_PEEK;
    else                          c.command = CMD_FLUSH;
    return c;
  endfunction

  // Stimulus
  initial begin
    int post_pct;
    bit mode;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reject mode, empty reads, fill, full reject
    write_overwrite(1'b0);
    issue_command(plain_command(CMD_GET));
    issue_command(plain_command(CMD_PEEK));
    issue_command(post_event(6'h3F, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    issue_command(post_event(6'h00, 2'd0, 32'd0, 32'd0, 32'd0));
    issue_command(post_event(6'h15, 2'd1, 32'd0, 32'hA5A5_5A5A, 32'h1234_5678));
    issue_command(post_event(6'h2A, 2'd2, 32'd1, 32'h5A5A_A5A5, 32'hFFFF_FFFF));
    for (int i = 0; i < 4; i++) issue_command(random_command(100));
    issue_command(post_event(6'h11, 2'd1, 32'h0000_0042, 32'hDEAD_BEEF, 32'd7));
    issue_command(plain_command(CMD_PEEK));
    issue_command(plain_command(CMD_GET));
    drain_results();

    // Directed: overwrite mode, fill, overwrite the oldest, flush
    write_overwrite(1'b1);
    issue_command(post_event(6'h01, 2'd2, 32'd0, 32'h0000_0001, 32'h8000_0000));
    issue_command(post_event(6'h3E, 2'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'd3));
    issue_command(plain_command(CMD_GET));
    issue_command(plain_command(CMD_FLUSH));
    issue_command(plain_command(CMD_GET));
    issue_command(plain_command(CMD_PEEK));
    drain_results();

    // Random phases, alternating mode, varying how full the queue runs
    for (int ph = 0; ph < PHASES; ph++) begin
      mode = (ph == PHASES - 1) ? 1'($urandom) : ~ph[0];
      write_overwrite(mode);
      post_pct = $urandom_range(35, 75);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        issue_command(random_command(post_pct));
        if (ph < PHASES - 1 && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 6));
      end
      drain_results();
    end

    repeat (5) @(posedge clk);
    $display("Ran %0d commands, checked %0d results in both overwrite modes.",
             issued, sb.checked);
    $display("Full rejects %0d, full overwrites %0d, empty reads %0d.",
             sb.full_rejects, sb.full_overwrites, sb.empty_reads);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/erq_pkg.sv
hdl/erq_cell.sv
hdl/erq_ctrl.sv
hdl/event_ring_queue_overwrite_core.sv
dv/tb_top.sv
